// ===== rtl/ovf_pkg.sv =====
// Shared types, codes and field layout of the overlapping frame FIFO.
`timescale 1ns / 1ps

package ovf_pkg;

  // Default sizes of the top level
  localparam int DEPTH_DEF       = 256;
  localparam int CHANNELS_DEF    = 4;
  localparam int MAX_POP_DEF     = 64;
  localparam int SAMPLE_BITS_DEF = 24;

  // Field widths on the ports
  localparam int NUM_LANES  = 4;
  localparam int SAMPLE_W   = 24;
  localparam int CAP_W      = 9;
  localparam int BLOCK_W    = 9;
  localparam int POP_W      = 7;
  localparam int KEEP_W     = 6;
  localparam int OPCODE_W   = 2;
  localparam int STATUS_W   = 2;
  localparam int ROWS_W     = 7;

  // Input tdata layout, lowest bit first
  localparam int IN_BLOCK_LSB  = 0;
  localparam int IN_POP_LSB    = IN_BLOCK_LSB + BLOCK_W;
  localparam int IN_KEEP_LSB   = IN_POP_LSB + POP_W;
  localparam int IN_SAMPLE_LSB = IN_KEEP_LSB + KEEP_W;
  localparam int IN_USED_W     = IN_SAMPLE_LSB + NUM_LANES * SAMPLE_W;
  localparam int IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout, lowest bit first
  localparam int OUT_STATUS_LSB = 0;
  localparam int OUT_SAMPLE_LSB = OUT_STATUS_LSB + STATUS_W;
  localparam int OUT_ROWS_LSB   = OUT_SAMPLE_LSB + NUM_LANES * SAMPLE_W;
  localparam int OUT_USED_W     = OUT_ROWS_LSB + ROWS_W;
  localparam int OUT_TDATA_W    = ((OUT_USED_W + 7) / 8) * 8;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_START = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ROW   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_POP   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_KEEP = 2'd2;

  // Result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_ROW    = 1'b1;

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take_start;
    logic take_row;
    logic take_pop;
    logic stream;
  } ovf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic pop_streams;
    logic stream_done;
  } ovf_stat_t;

endpackage

// ===== rtl/ovf_ctrl.sv =====
// Controller state machine: item acceptance and pop streaming sequence.
`timescale 1ns / 1ps

module ovf_ctrl import ovf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [OPCODE_W-1:0] in_opcode,
  output logic                in_ready,
  input  ovf_stat_t           stat,
  output ovf_cmd_t            cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          case (in_opcode)
            OP_START: cmd.take_start = 1'b1;
            OP_ROW:   cmd.take_row   = 1'b1;
            OP_POP: begin
              cmd.take_pop = 1'b1;
              if (stat.pop_streams) begin
                state_nxt = S_POP;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        cmd.stream = 1'b1;
        if (stat.stream_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/ovf_dp.sv =====
// Datapath: row store, pointers, fill tracking and the result register.
`timescale 1ns / 1ps

module ovf_dp import ovf_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int MAX_POP     = MAX_POP_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [CAP_W-1:0]    cfg_data,
  input  ovf_cmd_t            cmd,
  output ovf_stat_t           stat,
  input  logic [BLOCK_W-1:0]  block_rows,
  input  logic [POP_W-1:0]    pop_rows,
  input  logic [KEEP_W-1:0]   keep_rows,
  input  logic [SAMPLE_W-1:0] in_sample [NUM_LANES],
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_kind,
  output logic [STATUS_W-1:0] out_status,
  output logic [SAMPLE_W-1:0] out_sample [NUM_LANES],
  output logic [ROWS_W-1:0]   out_rows,
  output logic                out_last
);

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int AW     = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;
  localparam int GOT_W  = $clog2(MAX_POP + 1);
  localparam int WORD_W = CHANNELS * SAMPLE_BITS;

  logic [CAP_W-1:0]    cap_r;
  logic [PTR_W-1:0]    rd_ptr_r, wr_ptr_r, rd_addr_r;
  logic [CNT_W-1:0]    fill_r;
  logic [BLOCK_W-1:0]  left_r;
  logic                acc_r;
  logic [GOT_W-1:0]    issue_left_r, emit_left_r;
  logic [ROWS_W-1:0]   got_r;
  logic                rdv_r;
  logic [WORD_W-1:0]   rd_data_r;
  logic [WORD_W-1:0]   mem [DEPTH];
  logic [WORD_W-1:0]   wr_word;

  logic                out_valid_r, out_kind_r, out_last_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ROWS_W-1:0]   out_rows_r;
  logic [SAMPLE_W-1:0] out_sample_r [NUM_LANES];
  logic [SAMPLE_W-1:0] rd_sample [NUM_LANES];

  logic [AW-1:0]       cap_a, eff_cap, fill_a, req_a, got_a, dec_a, adv_a;
  logic [PTR_W-1:0]    rd_ptr_adv;
  logic                full, keep_ok, wr_en, out_free, move, issue;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Capacity, fill and pop size arithmetic
  always_comb begin
    cap_a   = AW'(cap_r);
    eff_cap = (cap_a > AW'(DEPTH)) ? AW'(DEPTH) : cap_a;
    fill_a  = AW'(fill_r);
    full    = (fill_a + AW'(block_rows)) > eff_cap;
    req_a   = (AW'(pop_rows) > AW'(MAX_POP)) ? AW'(MAX_POP) : AW'(pop_rows);
    got_a   = (req_a < fill_a) ? req_a : fill_a;
    keep_ok = got_a > AW'(keep_rows);
    dec_a   = got_a - AW'(keep_rows);
    adv_a   = AW'(rd_ptr_r) + dec_a;
    rd_ptr_adv = (adv_a >= AW'(DEPTH)) ? PTR_W'(adv_a - AW'(DEPTH)) : PTR_W'(adv_a);
  end

  assign wr_en    = cmd.take_row && acc_r && (left_r != '0) && (fill_a < eff_cap);
  assign out_free = !out_valid_r || out_ready;
  assign move     = rdv_r && out_free;
  assign issue    = cmd.stream && (issue_left_r != '0) && (!rdv_r || move);

  assign stat.out_free    = out_free;
  assign stat.pop_streams = keep_ok;
  assign stat.stream_done = (issue_left_r == '0) && !rdv_r;

  // Pack and unpack the stored row, one lane per channel
  for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
    if (c < CHANNELS) begin : g_used
      logic signed [SAMPLE_BITS-1:0] rd_raw;
      assign wr_word[c*SAMPLE_BITS +: SAMPLE_BITS] = in_sample[c][SAMPLE_BITS-1:0];
      assign rd_raw       = rd_data_r[c*SAMPLE_BITS +: SAMPLE_BITS];
      assign rd_sample[c] = SAMPLE_W'(rd_raw);
    end else begin : g_unused
      assign rd_sample[c] = '0;
    end
  end

  // Row store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_word;
    end
    if (issue) begin
      rd_data_r <= mem[rd_addr_r];
    end
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_W'(256);
    end else if (cfg_valid) begin
      cap_r <= cfg_data;
    end
  end

  // Queue state: pointers, fill and block bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      fill_r   <= '0;
      left_r   <= '0;
      acc_r    <= 1'b0;
    end else begin
      if (cmd.take_start) begin
        acc_r  <= !full;
        left_r <= block_rows;
      end
      if (cmd.take_row && (left_r != '0)) begin
        left_r <= left_r - 1'b1;
      end
      if (wr_en) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
        fill_r   <= fill_r + 1'b1;
      end
      if (cmd.take_pop && keep_ok) begin
        rd_ptr_r <= rd_ptr_adv;
        fill_r   <= fill_r - CNT_W'(dec_a);
      end
    end
  end

  // Pop streaming counters and read stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_left_r <= '0;
      emit_left_r  <= '0;
      rdv_r        <= 1'b0;
    end else begin
      if (cmd.take_pop && keep_ok) begin
        issue_left_r <= GOT_W'(got_a);
        emit_left_r  <= GOT_W'(got_a);
      end else begin
        if (issue) begin
          issue_left_r <= issue_left_r - 1'b1;
        end
        if (move) begin
          emit_left_r <= emit_left_r - 1'b1;
        end
      end
      if (issue) begin
        rdv_r <= 1'b1;
      end else if (move) begin
        rdv_r <= 1'b0;
      end
    end
  end

  // Read address and beat count of the current pop
  always_ff @(posedge clk) begin
    if (cmd.take_pop && keep_ok) begin
      rd_addr_r <= rd_ptr_r;
      got_r     <= got_a[ROWS_W-1:0];
    end else if (issue) begin
      rd_addr_r <= ptr_inc(rd_addr_r);
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.take_start || (cmd.take_pop && !keep_ok) || move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (cmd.take_start) begin
      out_kind_r   <= KIND_STATUS;
      out_status_r <= full ? ST_FULL : ST_OK;
      out_rows_r   <= '0;
      out_last_r   <= 1'b1;
      for (int c = 0; c < NUM_LANES; c++) out_sample_r[c] <= '0;
    end else if (cmd.take_pop && !keep_ok) begin
      out_kind_r   <= KIND_STATUS;
      out_status_r <= ST_KEEP;
      out_rows_r   <= got_a[ROWS_W-1:0];
      out_last_r   <= 1'b1;
      for (int c = 0; c < NUM_LANES; c++) out_sample_r[c] <= '0;
    end else if (move) begin
      out_kind_r   <= KIND_ROW;
      out_status_r <= ST_OK;
      out_rows_r   <= got_r;
      out_last_r   <= (emit_left_r == GOT_W'(1));
      for (int c = 0; c < NUM_LANES; c++) out_sample_r[c] <= rd_sample[c];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_status = out_status_r;
  assign out_rows   = out_rows_r;
  assign out_last   = out_last_r;
  assign out_sample = out_sample_r;

endmodule

// ===== rtl/overlap_frame_fifo.sv =====
// A status result is registered and appears in the cycle after its item is accepted.
// A pop's rows pass the read address, read data and result registers, then stream one
// row per cycle while the sink is ready; input is held off while they stream, paced by
// the single row store read port. Pushes and push starts are taken one per cycle while
// the output is free. Reset (rst_n low, synchronous) empties the queue, drops the output
// beat and sets capacity to 256; the row store itself is not cleared.
`timescale 1ns / 1ps

module overlap_frame_fifo import ovf_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int MAX_POP     = MAX_POP_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration: capacity
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CAP_W-1:0]       cfg_data,
  // Input beats
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // block_rows, pop_rows, keep_rows, sample_0, sample_1, sample_2, sample_3
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // opcode
  input  logic [OPCODE_W-1:0]    in_tuser,
  // Result beats
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status, out_sample_0, out_sample_1, out_sample_2, out_sample_3, rows_obtained
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // kind
  output logic                   out_tuser,
  output logic                   out_tlast
);

  ovf_cmd_t            cmd;
  ovf_stat_t           stat;
  logic [SAMPLE_W-1:0] in_sample  [NUM_LANES];
  logic [SAMPLE_W-1:0] out_sample [NUM_LANES];
  logic [STATUS_W-1:0] out_status;
  logic [ROWS_W-1:0]   out_rows;

  assign cfg_ready = 1'b1;

  // Unpack input samples and pack result samples
  for (genvar c = 0; c < NUM_LANES; c++) begin : g_pack
    assign in_sample[c] = in_tdata[IN_SAMPLE_LSB + c*SAMPLE_W +: SAMPLE_W];
    assign out_tdata[OUT_SAMPLE_LSB + c*SAMPLE_W +: SAMPLE_W] = out_sample[c];
  end

  assign out_tdata[OUT_STATUS_LSB +: STATUS_W] = out_status;
  assign out_tdata[OUT_ROWS_LSB +: ROWS_W]     = out_rows;
  assign out_tdata[OUT_TDATA_W-1:OUT_USED_W]   = '0;

  ovf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_opcode (in_tuser),
    .in_ready  (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ovf_dp #(
    .DEPTH       (DEPTH),
    .CHANNELS    (CHANNELS),
    .MAX_POP     (MAX_POP),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .block_rows (in_tdata[IN_BLOCK_LSB +: BLOCK_W]),
    .pop_rows   (in_tdata[IN_POP_LSB +: POP_W]),
    .keep_rows  (in_tdata[IN_KEEP_LSB +: KEEP_W]),
    .in_sample  (in_sample),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (out_tuser),
    .out_status (out_status),
    .out_sample (out_sample),
    .out_rows   (out_rows),
    .out_last   (out_tlast)
  );

endmodule

// ===== rtl/ovf_checker.sv =====
// Port-level checks of the overlapping frame FIFO, bound to the top level.
`timescale 1ns / 1ps

module ovf_checker import ovf_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tlast
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // Drop the result beat on reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Status results are single beats
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_STATUS) |-> out_tlast)
    else $error("status beat without tlast");

  // Row beats carry an ok status
  a_row_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_ROW) |->
      (out_tdata[OUT_STATUS_LSB +: STATUS_W] == ST_OK))
    else $error("row beat with nonzero status");

  // Hold input off while a frame is still streaming
  a_frame_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_ROW) && !out_tlast |-> !in_tready)
    else $error("input accepted in the middle of a frame");

endmodule

bind overlap_frame_fifo ovf_checker u_ovf_checker (.*);

// ===== verif/overlap_frame_fifo_chk.sv =====
// Scoreboard for the overlap frame FIFO: tracks queue state, predicts result beats, compares.
`timescale 1ns / 1ps

module overlap_frame_fifo_chk import ovf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CAP_W-1:0]       cfg_data,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // block_rows, pop_rows, keep_rows, sample_0, sample_1, sample_2, sample_3
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // opcode
  input  logic [OPCODE_W-1:0]    in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // status, out_sample_0, out_sample_1, out_sample_2, out_sample_3, rows_obtained
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  // kind
  input  logic                   out_tuser,
  input  logic                   out_tlast,
  output int                     errors,
  output int                     beats_due,
  output int                     beats_checked,
  output int                     rows_queued
);

  localparam int STORE_ROWS = DEPTH_DEF;
  localparam int POP_LIMIT  = MAX_POP_DEF;
  localparam int SHOW_LIMIT = 10;

  typedef logic [NUM_LANES-1:0][SAMPLE_W-1:0] lanes_t;

  typedef struct packed {
    logic              kind;
    logic [STATUS_W-1:0] status;
    lanes_t            smp;
    logic [ROWS_W-1:0] rows;
    logic              last;
  } fifo_beat_t;

  // Predicted queue state
  lanes_t     row_mem [STORE_ROWS];
  int         head;
  int         tail;
  int         fill;
  int         rows_left;
  logic       blk_ok;
  int         cap;
  fifo_beat_t due_q [$];

  initial begin
    errors        = 0;
    beats_checked = 0;
    beats_due     = 0;
    rows_queued   = 0;
  end

  function automatic int usable_cap();
    return (cap > STORE_ROWS) ? STORE_ROWS : cap;
  endfunction

  function automatic fifo_beat_t status_beat(logic [STATUS_W-1:0] st, int got);
    fifo_beat_t b;
    b        = '0;
    b.kind   = KIND_STATUS;
    b.status = st;
    b.rows   = got[ROWS_W-1:0];
    b.last   = 1'b1;
    return b;
  endfunction

  // Advance the queue model by one input beat and queue up the beats it causes
  task automatic apply_fifo_op(logic [OPCODE_W-1:0] op, logic [IN_TDATA_W-1:0] d);
    int         n;
    int         req;
    int         keep;
    int         got;
    fifo_beat_t b;
    case (op)
      OP_START: begin
        n         = int'(d[IN_BLOCK_LSB +: BLOCK_W]);
        blk_ok    = (fill + n <= usable_cap());
        rows_left = n;
        due_q.push_back(status_beat(blk_ok ? ST_OK : ST_FULL, 0));
      end
      OP_ROW: begin
        // rows outside a block, of a rejected block or past capacity are dropped
        if (rows_left != 0) begin
          rows_left--;
          if (blk_ok && fill < usable_cap()) begin
            // full-width samples pass through untouched
            row_mem[tail] = d[IN_SAMPLE_LSB +: NUM_LANES*SAMPLE_W];
            tail          = (tail + 1) % STORE_ROWS;
            fill++;
          end
        end
      end
      OP_POP: begin
        req  = int'(d[IN_POP_LSB +: POP_W]);
        keep = int'(d[IN_KEEP_LSB +: KEEP_W]);
        if (req > POP_LIMIT) req = POP_LIMIT;
        got = (req < fill) ? req : fill;
        if (got <= keep) begin
          due_q.push_back(status_beat(ST_KEEP, got));
        end else begin
          for (int k = 0; k < got; k++) begin
            b      = '0;
            b.kind = KIND_ROW;
            b.smp  = row_mem[(head + k) % STORE_ROWS];
            b.rows = got[ROWS_W-1:0];
            b.last = (k == got - 1);
            due_q.push_back(b);
          end
          // hold back the last keep rows for the next frame
          head = (head + got - keep) % STORE_ROWS;
          fill = fill - (got - keep);
        end
      end
      default: ;
    endcase
  endtask

  // Compare one result beat against the oldest prediction
  task automatic check_beat();
    fifo_beat_t act;
    fifo_beat_t exp_b;
    string      bad;
    act.kind   = out_tuser;
    act.status = out_tdata[OUT_STATUS_LSB +: STATUS_W];
    act.smp    = out_tdata[OUT_SAMPLE_LSB +: NUM_LANES*SAMPLE_W];
    act.rows   = out_tdata[OUT_ROWS_LSB +: ROWS_W];
    act.last   = out_tlast;
    beats_checked++;
    if (due_q.size() == 0) begin
      errors++;
      if (errors <= SHOW_LIMIT)
        $display("unexpected result beat: kind %0d status %0d rows %0d last %0d samples %h",
                 act.kind, act.status, act.rows, act.last, act.smp);
      return;
    end
    exp_b = due_q.pop_front();
    bad   = "";
    if (act.kind !== exp_b.kind) bad = {bad, " kind"};
    if (act.status !== exp_b.status) bad = {bad, " status"};
    for (int c = 0; c < NUM_LANES; c++)
      if (act.smp[c] !== exp_b.smp[c]) bad = {bad, $sformatf(" sample_%0d", c)};
    if (act.rows !== exp_b.rows) bad = {bad, " rows_obtained"};
    if (act.last !== exp_b.last) bad = {bad, " last"};
    if (bad != "") begin
      errors++;
      if (errors <= SHOW_LIMIT) begin
        $display("mismatch on result beat %0d, fields:%s", beats_checked, bad);
        $display("  expected kind %0d status %0d rows %0d last %0d samples %h",
                 exp_b.kind, exp_b.status, exp_b.rows, exp_b.last, exp_b.smp);
        $display("  actual   kind %0d status %0d rows %0d last %0d samples %h",
                 act.kind, act.status, act.rows, act.last, act.smp);
      end
    end
  endtask

  // Track every handshake at the clock edge; an item sees the capacity held before the edge
  always @(posedge clk) begin
    if (!rst_n) begin
      head      = 0;
      tail      = 0;
      fill      = 0;
      rows_left = 0;
      blk_ok    = 1'b0;
      cap       = 256;
      due_q.delete();
    end else begin
      if (in_tvalid && in_tready) apply_fifo_op(in_tuser, in_tdata);
      if (cfg_valid && cfg_ready) cap = int'(cfg_data);
      if (out_tvalid && out_tready) check_beat();
    end
    beats_due   <= due_q.size();
    rows_queued <= fill;
  end

endmodule

// ===== verif/overlap_frame_fifo_tb.sv =====
// Stimulus and verdict for the overlap frame FIFO, with the scoreboard beside the block.
`timescale 1ns / 1ps

module overlap_frame_fifo_tb;
  import ovf_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_NONE = 2'd3;  // opcode the block ignores
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 8;
  localparam int PHASE_BEATS = 32;
  localparam int ROW_W       = NUM_LANES * SAMPLE_W;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CAP_W-1:0]       cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [OPCODE_W-1:0]    in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  int   mismatches;
  int   beats_due;
  int   beats_checked;
  int   rows_queued;
  int   items_sent;
  int   caps_written;
  int   quiet_cycles;
  logic idle_on;
  logic hold_now;

  int   cap_plan [6] = '{40, 1, 0, 511, 100, 256};

  overlap_frame_fifo uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  overlap_frame_fifo_chk chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .errors       (mismatches),
    .beats_due    (beats_due),
    .beats_checked(beats_checked),
    .rows_queued  (rows_queued)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog: end the run if no beat moves on any channel for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
               quiet_cycles, beats_due);
      $display("overlap_frame_fifo_tb: errors");
      $finish;
    end
  end

  // Result sink: short random stalls, plus one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_now) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_now = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pack_item(int blk, int req, int keep,
                                                       logic [ROW_W-1:0] smp);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[IN_BLOCK_LSB +: BLOCK_W]  = blk[BLOCK_W-1:0];
    d[IN_POP_LSB +: POP_W]      = req[POP_W-1:0];
    d[IN_KEEP_LSB +: KEEP_W]    = keep[KEEP_W-1:0];
    d[IN_SAMPLE_LSB +: ROW_W]   = smp;
    return d;
  endfunction

  function automatic logic [ROW_W-1:0] noise_row();
    return {$urandom, $urandom, $urandom};
  endfunction

  // Mostly random rows, some built from full-scale and zero samples
  function automatic logic [ROW_W-1:0] pick_row();
    logic [NUM_LANES-1:0][SAMPLE_W-1:0] r;
    if ($urandom_range(0, 4) != 0) return noise_row();
    for (int c = 0; c < NUM_LANES; c++)
      case ($urandom_range(0, 4))
        0:       r[c] = 24'h800000;
        1:       r[c] = 24'h7FFFFF;
        2:       r[c] = 24'h000000;
        3:       r[c] = 24'hFFFFFF;
        default: r[c] = SAMPLE_W'($urandom);
      endcase
    return r;
  endfunction

  // Offer one input beat and hold it until it is taken
  task automatic send(logic [OPCODE_W-1:0] op, logic [IN_TDATA_W-1:0] d);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic push_start(int n);
    send(OP_START, pack_item(n, $urandom, $urandom, noise_row()));
  endtask

  task automatic push_row(logic [ROW_W-1:0] smp);
    send(OP_ROW, pack_item($urandom, $urandom, $urandom, smp));
  endtask

  task automatic pop_req(int req, int keep);
    send(OP_POP, pack_item($urandom, req, keep, noise_row()));
  endtask

  // Stop offering and wait until every predicted result has come out
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (beats_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cap(int v);
    cfg_valid <= 1'b1;
    cfg_data  <= v[CAP_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    caps_written++;
  endtask

  // A push block, sometimes oversized, cut short or followed by stray rows
  task automatic random_block();
    int n;
    int rows;
    case ($urandom_range(0, 9))
      0:       n = $urandom_range(0, 511);
      1:       n = $urandom_range(13, 40);
      default: n = $urandom_range(1, 12);
    endcase
    push_start(n);
    rows = (n > 40) ? $urandom_range(0, 8) : n;
    case ($urandom_range(0, 19))
      0:       rows = $urandom_range(0, rows);
      1:       rows = rows + $urandom_range(1, 2);
      default: ;
    endcase
    for (int i = 0; i < rows; i++) push_row(pick_row());
  endtask

  // A pop sized to the current fill most of the time, so frames really come out
  task automatic random_pop();
    int f;
    int req;
    int got;
    int lim;
    int keep;
    int k2;
    f = rows_queued;
    if ($urandom_range(0, 9) < 8) req = $urandom_range(1, ((f < MAX_POP_DEF) ? f : MAX_POP_DEF) + 2);
    else req = $urandom_range(0, 127);
    got = (req > MAX_POP_DEF) ? MAX_POP_DEF : req;
    if (got > f) got = f;
    if (got > 0 && $urandom_range(0, 9) < 8) begin
      lim  = (got - 1 > 63) ? 63 : got - 1;
      keep = $urandom_range(0, lim);
      k2   = $urandom_range(0, lim);
      if (k2 < keep) keep = k2;
    end else begin
      keep = $urandom_range(0, 63);
    end
    pop_req(req, keep);
  endtask

  task automatic noise_item();
    case ($urandom_range(0, 2))
      0:       send(OP_NONE, pack_item($urandom, $urandom, $urandom, noise_row()));
      1:       push_row(noise_row());
      default: pop_req(0, $urandom_range(0, 63));
    endcase
  endtask

  task automatic run_phase(int quota);
    int pick;
    while (items_sent < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) random_block();
      else if (pick < 85) random_pop();
      else noise_item();
    end
  endtask

  initial begin
    logic [NUM_LANES-1:0][SAMPLE_W-1:0] r;
    rst_n        <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_data     <= '0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    in_tuser     <= OP_START;
    items_sent   = 0;
    caps_written = 0;
    quiet_cycles = 0;
    idle_on      = 1'b1;
    hold_now     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Pops on an empty queue, including a zero-row request
    pop_req(1, 0);
    pop_req(0, 0);
    // Empty block, then a row that belongs to no block
    push_start(0);
    push_row(noise_row());
    // Oversized block is rejected and its rows dropped
    push_start(511);
    push_row(noise_row());
    push_row(noise_row());
    // Block that exactly fills capacity, abandoned by the next start
    push_start(256);
    push_start(4);
    r = {24'hFFFFFF, 24'h000000, 24'h800000, 24'h7FFFFF};
    push_row(r);
    r = {24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'h000000};
    push_row(r);
    r = {24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF};
    push_row(r);
    push_row(noise_row());
    push_row(noise_row());
    send(OP_NONE, pack_item($urandom, $urandom, $urandom, noise_row()));
    // Keep not below obtained, with the request saturated
    pop_req(127, 63);
    // Overlapping frame, then keep equal to obtained, then the rest
    pop_req(3, 1);
    pop_req(64, 2);
    pop_req(100, 0);
    // Block cut short by a new start
    push_start(3);
    push_row(pick_row());
    push_start(2);
    push_row(pick_row());
    push_row(pick_row());
    pop_req(127, 0);
    settle();

    // Fill the queue while the sink holds off, so the input backs up
    write_cap(256);
    hold_now = 1'b1;
    push_start(70);
    for (int i = 0; i < 70; i++) push_row(pick_row());
    pop_req(127, 3);
    pop_req(10, 2);
    push_start(5);
    for (int i = 0; i < 5; i++) push_row(pick_row());
    settle();
    run_phase(items_sent + PHASE_BEATS);

    foreach (cap_plan[p]) begin
      if (p == $size(cap_plan) - 1) idle_on = 1'b0;
      if (cap_plan[p] == 1) begin
        // Shrink capacity in the middle of an accepted block
        pop_req(64, 0);
        push_start(6);
        push_row(pick_row());
        push_row(pick_row());
        settle();
        write_cap(cap_plan[p]);
        for (int i = 0; i < 4; i++) push_row(pick_row());
        pop_req(64, 0);
      end else begin
        settle();
        write_cap(cap_plan[p]);
      end
      run_phase(items_sent + PHASE_BEATS);
    end

    settle();
    $display("run covered %0d input beats under %0d capacity writes; %0d result beats checked",
             items_sent, caps_written, beats_checked);
    if (mismatches == 0 && beats_due == 0)
      $display("overlap_frame_fifo_tb: clean");
    else
      $display("overlap_frame_fifo_tb: errors");
    $finish;
  end

endmodule
